[hw/rtl/cocktail_shaker_sort_defines.svh]
// assertion macros for the shaker sorter, compiled out for synthesis
`ifndef COCKTAIL_SHAKER_SORT_DEFINES_SVH
`define COCKTAIL_SHAKER_SORT_DEFINES_SVH

`ifndef SYNTHESIS

// condition must hold at every clock edge outside reset
`define CSS_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("css assertion failed");

// consequent must hold in the cycle after the antecedent
`define CSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("css assertion failed");

`else

`define CSS_ASSERT_ALWAYS(lbl, expr)
`define CSS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[hw/rtl/css_pkg.sv]
`timescale 1ns / 1ps

package css_pkg;

  localparam int DEPTH   = 16;
  localparam int VAL_W   = 32;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // one queued element, already classified by the front end
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    keep;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[hw/rtl/css_if.sv]
`timescale 1ns / 1ps

interface css_in_if import css_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic                    last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface css_out_if import css_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value_res;
  logic                    last_res;
  logic                    overflow;

  modport source (output valid, output value_res, output last_res, output overflow,
                  input ready);
  modport sink (input valid, input value_res, input last_res, input overflow,
                output ready);
endinterface

[hw/rtl/css_front.sv]
`timescale 1ns / 1ps

module css_front import css_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  css_in_if.sink    in_ch,
  input  q_status_t q_stat,
  output logic      push,
  output item_t     push_item
);

  // elements seen in the current set, saturating at capacity
  logic [CNT_W-1:0] seen_r;
  logic [CNT_W-1:0] seen_nxt;
  logic             keep;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && in_ch.ready;
  assign keep        = seen_r < CNT_W'(DEPTH);

  assign push_item.value = in_ch.value;
  assign push_item.last  = in_ch.last;
  assign push_item.keep  = keep;

  always_comb begin
    seen_nxt = seen_r;
    if (push) begin
      if (in_ch.last) begin
        seen_nxt = '0;
      end else if (keep) begin
        seen_nxt = seen_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

endmodule

[hw/rtl/css_queue.sv]
`timescale 1ns / 1ps

`include "cocktail_shaker_sort_defines.svh"

module css_queue import css_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  item_t     push_item,
  input  logic      pop,
  output item_t     pop_item,
  output q_status_t q_stat
);

  item_t              q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] fill_r;
  logic [Q_CNT_W-1:0] fill_nxt;

  assign q_stat.full  = fill_r == Q_CNT_W'(Q_DEPTH);
  assign q_stat.empty = fill_r == '0;
  assign pop_item     = q_mem[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      fill_r <= fill_nxt;
    end
  end

  `CSS_ASSERT_ALWAYS(a_no_push_full, !(push && q_stat.full))
  `CSS_ASSERT_ALWAYS(a_no_pop_empty, !(pop && q_stat.empty))
  `CSS_ASSERT_NEXT(a_push_fills, push && !pop, !q_stat.empty)

endmodule

[hw/rtl/css_back.sv]
`timescale 1ns / 1ps

`include "cocktail_shaker_sort_defines.svh"

module css_back import css_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  item_t     pop_item,
  input  q_status_t q_stat,
  output logic      pop,
  css_out_if.source out_ch
);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_FRD   = 4'd2;
  localparam logic [3:0] S_FCMP  = 4'd3;
  localparam logic [3:0] S_FWB   = 4'd4;
  localparam logic [3:0] S_BRD   = 4'd5;
  localparam logic [3:0] S_BCMP  = 4'd6;
  localparam logic [3:0] S_BWB   = 4'd7;
  localparam logic [3:0] S_ERD   = 4'd8;
  localparam logic [3:0] S_ESEND = 4'd9;

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rd_a_r;
  logic signed [VAL_W-1:0] rd_b_r;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             drop_r, drop_nxt;
  logic [IDX_W-1:0] lo_r, lo_nxt;
  logic [IDX_W-1:0] hi_r, hi_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] mark_r, mark_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_ovf_r, out_ovf_nxt;

  logic                    mem_we;
  logic [IDX_W-1:0]        mem_wa;
  logic signed [VAL_W-1:0] mem_wd;
  logic                    rd_en;
  logic [IDX_W-1:0]        ra, rb;
  logic                    gt;
  logic                    fwd_step, bwd_step;
  logic [CNT_W-1:0]        cnt_m1;
  logic                    emit_last;

  assign gt        = rd_a_r > rd_b_r;
  assign cnt_m1    = count_r - CNT_W'(1);
  assign emit_last = CNT_W'(idx_r) == cnt_m1;
  assign ra        = (state_r == S_BRD) ? idx_r - IDX_W'(1) : idx_r;
  assign rb        = (state_r == S_BRD) ? idx_r : idx_r + IDX_W'(1);
  assign rd_en     = (state_r == S_FRD) || (state_r == S_BRD) || (state_r == S_ERD);

  assign out_ch.valid     = out_valid_r;
  assign out_ch.value_res = out_value_r;
  assign out_ch.last_res  = out_last_r;
  assign out_ch.overflow  = out_ovf_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    idx_nxt       = idx_r;
    mark_nxt      = mark_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    mem_we        = 1'b0;
    mem_wa        = idx_r;
    mem_wd        = rd_b_r;
    pop           = 1'b0;
    fwd_step      = 1'b0;
    bwd_step      = 1'b0;

    unique case (state_r)
      S_LOAD: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          if (pop_item.keep) begin
            mem_we    = 1'b1;
            mem_wa    = count_r[IDX_W-1:0];
            mem_wd    = pop_item.value;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (pop_item.last) begin
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        lo_nxt    = '0;
        hi_nxt    = IDX_W'(cnt_m1);
        mark_nxt  = '0;
        idx_nxt   = '0;
        state_nxt = (count_r > CNT_W'(1)) ? S_FRD : S_ERD;
      end
      S_FRD: begin
        state_nxt = S_FCMP;
      end
      S_FCMP: begin
        if (gt) begin
          mem_we    = 1'b1;
          mem_wa    = idx_r;
          mem_wd    = rd_b_r;
          mark_nxt  = idx_r;
          state_nxt = S_FWB;
        end else begin
          fwd_step = 1'b1;
        end
      end
      S_FWB: begin
        mem_we   = 1'b1;
        mem_wa   = idx_r + IDX_W'(1);
        mem_wd   = rd_a_r;
        fwd_step = 1'b1;
      end
      S_BRD: begin
        state_nxt = S_BCMP;
      end
      S_BCMP: begin
        if (gt) begin
          mem_we    = 1'b1;
          mem_wa    = idx_r - IDX_W'(1);
          mem_wd    = rd_b_r;
          mark_nxt  = idx_r;
          state_nxt = S_BWB;
        end else begin
          bwd_step = 1'b1;
        end
      end
      S_BWB: begin
        mem_we   = 1'b1;
        mem_wa   = idx_r;
        mem_wd   = rd_a_r;
        bwd_step = 1'b1;
      end
      S_ERD: begin
        state_nxt = S_ESEND;
      end
      S_ESEND: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = rd_a_r;
          out_last_nxt  = emit_last;
          out_ovf_nxt   = drop_r;
          if (emit_last) begin
            count_nxt = '0;
            drop_nxt  = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    // end of a forward compare: next pair or turn round
    if (fwd_step) begin
      if (idx_r + IDX_W'(1) < hi_r) begin
        idx_nxt   = idx_r + IDX_W'(1);
        state_nxt = S_FRD;
      end else begin
        hi_nxt  = mark_r;
        idx_nxt = mark_r;
        if (mark_r > lo_r) begin
          state_nxt = S_BRD;
        end else begin
          lo_nxt    = mark_r;
          idx_nxt   = '0;
          state_nxt = S_ERD;
        end
      end
    end

    // end of a backward compare: next pair or turn round
    if (bwd_step) begin
      if (idx_r - IDX_W'(1) > lo_r) begin
        idx_nxt   = idx_r - IDX_W'(1);
        state_nxt = S_BRD;
      end else begin
        lo_nxt = mark_r;
        if (mark_r < hi_r) begin
          idx_nxt   = mark_r;
          state_nxt = S_FRD;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_ERD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_a_r <= mem[ra];
      rd_b_r <= mem[rb];
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    idx_r       <= idx_nxt;
    mark_r      <= mark_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CSS_ASSERT_ALWAYS(a_count_range, count_r <= CNT_W'(DEPTH))
  `CSS_ASSERT_ALWAYS(a_fwd_bound, state_r != S_FRD || idx_r < hi_r)
  `CSS_ASSERT_ALWAYS(a_bwd_bound, state_r != S_BRD || idx_r > lo_r)

endmodule

[hw/rtl/cocktail_shaker_sort.sv]
`timescale 1ns / 1ps

// channel   | modport | payload                          | transaction
// ----------+---------+----------------------------------+-----------------------
// in_ch     | sink    | value[31:0] signed, last         | one element of a set
// out_ch    | source  | value_res[31:0], last_res, ovf   | one sorted element
//
// loading takes one cycle per element, while the two-entry queue is not empty
// sorting reads each pair, then compares it, and a swap adds a write-back
// step, bounded by the single-write element memory
// emitting reads each result from memory, then loads the output register
// reset is synchronous, active low, and clears counts, flags and state
// the front end keeps accepting the next set while the back end sorts,
// until the queue fills; a stalled output holds the engine in its emit step

module cocktail_shaker_sort import css_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  css_in_if.sink     in_ch,
  css_out_if.source  out_ch
);

  // classified elements pass from front end to sort engine
  logic      push;
  item_t     push_item;
  logic      pop;
  item_t     pop_item;
  q_status_t q_stat;

  // front end: takes transactions, marks elements beyond capacity
  css_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // short queue so both sides stall independently
  css_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  // back end: stores the set, runs the shaker passes, emits in order
  css_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_item (pop_item),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

[dv/tb_cocktail_shaker_sort.sv]
`timescale 1ns / 1ps

module tb_cocktail_shaker_sort;
  import css_pkg::*;

  // extremes of the signed element range
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  localparam int unsigned ITEMS_PER_PHASE = 90;
  localparam int unsigned HOLD_OFF_CYCLES = 400;  // long enough to fill the queue and stall input
  localparam int unsigned SETTLE_CYCLES   = 100;  // quiet time after the last sorted element
  localparam int unsigned RESET_CYCLES    = 10;

  // kinds of random set content
  typedef enum int unsigned {
    SET_RANDOM,
    SET_NARROW,
    SET_ASCENDING,
    SET_DESCENDING,
    SET_EXTREMES
  } set_kind_e;

  // one expected element of a sorted set
  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    ovf;
  } sorted_elem_t;

  // keeps its own copy of the element store, sorts it on the closing element
  // and holds the sorted sets until the block hands them back
  class sort_scoreboard;
    logic signed [VAL_W-1:0] held [DEPTH];
    int unsigned             held_cnt;
    bit                      dropped;
    sorted_elem_t            sorted_q [$];
    int unsigned             mismatches;

    function new();
      held_cnt   = 0;
      dropped    = 0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return sorted_q.size();
    endfunction

    // bidirectional bubble passes, each bound pulled in to the last swap
    function void shaker_sort(int unsigned n);
      int unsigned             lo, hi, mark, i;
      logic signed [VAL_W-1:0] t;
      if (n < 2) return;
      lo = 0;
      hi = n - 1;
      while (lo < hi) begin
        mark = lo;
        for (i = lo; i < hi; i++) begin
          if (held[i] > held[i+1]) begin
            t         = held[i];
            held[i]   = held[i+1];
            held[i+1] = t;
            mark      = i;
          end
        end
        hi = mark;
        for (i = hi; i > lo; i--) begin
          if (held[i-1] > held[i]) begin
            t         = held[i-1];
            held[i-1] = held[i];
            held[i]   = t;
            mark      = i;
          end
        end
        lo = mark;
      end
    endfunction

    function void note_element(logic signed [VAL_W-1:0] v, logic l);
      sorted_elem_t e;
      int unsigned  k;
      if (held_cnt < DEPTH) begin
        held[held_cnt] = v;
        held_cnt++;
      end else begin
        dropped = 1'b1;
      end
      if (l) begin
        shaker_sort(held_cnt);
        for (k = 0; k < held_cnt; k++) begin
          e.value = held[k];
          e.last  = (k == held_cnt - 1);
          e.ovf   = dropped;
          sorted_q.push_back(e);
        end
        held_cnt = 0;
        dropped  = 1'b0;
      end
    endfunction

    function void check_result(logic signed [VAL_W-1:0] v, logic l, logic o);
      sorted_elem_t e;
      if (sorted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: sorted element with none outstanding: value %0d last %b ovf %b",
                   $realtime, v, l, o);
        return;
      end
      e = sorted_q.pop_front();
      if (e.value !== v || e.last !== l || e.ovf !== o) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: sorted element wrong: exp value %0d last %b ovf %b, got %0d %b %b",
                   $realtime, e.value, e.last, e.ovf, v, l, o);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  css_in_if  in_ch ();
  css_out_if out_ch ();

  cocktail_shaker_sort i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sort_scoreboard sb = new();

  // idle rates in percent, set by the main sequence per phase
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;

  // long receiver hold-offs: requested by the main sequence, served by the receiver
  int unsigned hold_reqs;
  int unsigned hold_done;

  // 20 ns period
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // transaction monitor, samples the pre-edge values at each rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_element(in_ch.value, in_ch.last);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.value_res, out_ch.last_res, out_ch.overflow);
    end
  end

  // receiver: random back-pressure, plus the occasional long hold-off counted here
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    hold_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_reqs != hold_done) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done++;
      end
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // offer one element, idling at random first; returns at the accepting edge
  task automatic send_element(input logic signed [VAL_W-1:0] v, input logic l);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= l;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // sender pause until every sorted element has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    // wait until the monitor has noted the closing element
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one whole set of random length and shape; returns the number of elements
  task automatic send_random_set(output int unsigned len);
    int unsigned             pick, i;
    set_kind_e               kind;
    logic signed [VAL_W-1:0] v, base, step;
    pick = $urandom_range(99);
    if (pick < 10)      len = DEPTH + 1 + $urandom_range(3);  // spills past the store
    else if (pick < 25) len = DEPTH;                          // exactly full
    else                len = 1 + $urandom_range(DEPTH - 2);
    kind = set_kind_e'($urandom_range(4));
    base = $urandom;
    step = $urandom_range(1000);
    for (i = 0; i < len; i++) begin
      case (kind)
        SET_RANDOM: begin
          v = $urandom;
        end
        SET_NARROW: begin
          // lots of equal values to exercise the compare on ties
          v = $urandom_range(6);
          v = v - 3;
        end
        SET_ASCENDING: begin
          v = base + step * i;
        end
        SET_DESCENDING: begin
          v = base - step * i;
        end
        default: begin
          case ($urandom_range(4))
            0:       v = VAL_MIN;
            1:       v = VAL_MAX;
            2:       v = 0;
            3:       v = -1;
            default: v = 1;
          endcase
        end
      endcase
      send_element(v, i == len - 1);
    end
  endtask

  task automatic random_phase(input int unsigned target);
    int unsigned sent, len;
    sent = 0;
    while (sent < target) begin
      send_random_set(len);
      sent += len;
    end
  endtask

  // main sequence
  initial begin
    int unsigned i;
    logic signed [VAL_W-1:0] v;
    hold_reqs    = 0;
    in_idle_pct  = 16;
    out_idle_pct = 60;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;
    in_ch.last   <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single element at the negative extreme
    send_element(VAL_MIN, 1'b1);
    // both extremes in the wrong order
    send_element(VAL_MAX, 1'b0);
    send_element(VAL_MIN, 1'b1);
    // equal values around zero
    send_element(0, 1'b0);
    send_element(-1, 1'b0);
    send_element(0, 1'b0);
    send_element(1, 1'b1);
    // one past the store: the closing element itself is dropped
    for (i = 0; i <= DEPTH; i++) begin
      case (i % 5)
        0:       v = VAL_MAX - i;
        1:       v = VAL_MIN + i;
        2:       v = 0;
        3:       v = -1;
        default: v = i;
      endcase
      send_element(v, i == DEPTH);
    end
    drain_results();

    // sender idles lightly, receiver heavily
    random_phase(ITEMS_PER_PHASE);
    drain_results();

    // the other way round
    in_idle_pct  = 60;
    out_idle_pct = 16;
    random_phase(ITEMS_PER_PHASE);
    drain_results();

    // no idling; a long receiver hold-off fills the block and stalls the input
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_reqs++;
    random_phase(ITEMS_PER_PHASE);
    drain_results();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("cocktail_shaker_sort: match");
    end else begin
      $display("cocktail_shaker_sort: mismatch");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #10000000;
    $display("cocktail_shaker_sort: mismatch");
    $finish;
  end

endmodule
